### rtl/tlpeq_pkg.sv
// ----------------------------------------------------------------------------
// tlpeq_pkg
// Shared constants, types and helpers of the three-level priority event queue.
// ----------------------------------------------------------------------------
package tlpeq_pkg;

    localparam int LEVEL_DEPTH = 16;
    localparam int EVENT_WIDTH = 32;
    localparam int NUM_LEVELS  = 3;

    localparam int HANDLE_W = (EVENT_WIDTH < 32) ? EVENT_WIDTH : 32;
    localparam int PTR_W    = $clog2(LEVEL_DEPTH);
    localparam int CNT_W    = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W   = $clog2(NUM_LEVELS * LEVEL_DEPTH);

    typedef logic [1:0]          t_level;
    typedef logic [PTR_W-1:0]    t_ptr;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [HANDLE_W-1:0] t_handle;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BADPRIO = 2'd3
    } t_status;

    localparam t_level LVL_HIGH    = 2'd0;
    localparam t_level LVL_MEDIUM  = 2'd1;
    localparam t_level LVL_LOW     = 2'd2;
    localparam t_level LVL_INVALID = 2'd3;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } t_cmd;

    function automatic t_ptr next_ptr(t_ptr p);
        t_ptr r;
        if (p == t_ptr'(LEVEL_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

    function automatic logic [4:0] cnt5(t_cnt c);
        logic [CNT_W+4:0] w;
        w = (CNT_W + 5)'(c);
        return w[4:0];
    endfunction

    function automatic t_addr slot_addr(t_level lvl, t_ptr p);
        return t_addr'(lvl) * t_addr'(LEVEL_DEPTH) + t_addr'(p);
    endfunction

endpackage

### rtl/tlpeq_ctrl.sv
// ----------------------------------------------------------------------------
// tlpeq_ctrl
// Sequencer: capture an item, execute it on the queues, load the result beat.
// ----------------------------------------------------------------------------
module tlpeq_ctrl
    import tlpeq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   out_free;
    t_cmd   cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.execute = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    cmd.load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.capture) begin
                r_in_stall <= 1'b1;
            end else if (cmd.load) begin
                r_in_stall <= 1'b0;
            end
            if (cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

### rtl/tlpeq_dp.sv
// ----------------------------------------------------------------------------
// tlpeq_dp
// Datapath: event store, per-level head, tail and count, result register.
// ----------------------------------------------------------------------------
module tlpeq_dp
    import tlpeq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_event_req,
    input  logic [1:0]  i_priority_req,
    input  logic        i_cfg_write,
    input  logic        i_cfg_deliver_enable,
    output logic [1:0]  o_status,
    output logic [31:0] o_event_out,
    output logic [1:0]  o_level_out,
    output logic        o_delivered,
    output logic [4:0]  o_count_high,
    output logic [4:0]  o_count_medium,
    output logic [4:0]  o_count_low
);

    logic    [HANDLE_W-1:0] mem [NUM_LEVELS*LEVEL_DEPTH];

    t_kind   r_kind;
    t_level  r_prio;
    t_handle r_handle;
    logic    r_deliver_enable;

    t_ptr    r_head  [NUM_LEVELS];
    t_ptr    r_tail  [NUM_LEVELS];
    t_cnt    r_count [NUM_LEVELS];

    t_status r_res_status;
    t_level  r_res_level;
    logic    r_res_dlv;
    logic    r_res_pop;
    t_handle r_rd_data;

    logic [1:0]  r_o_status;
    logic [31:0] r_o_event;
    logic [1:0]  r_o_level;
    logic        r_o_dlv;
    logic [4:0]  r_o_cnt_h;
    logic [4:0]  r_o_cnt_m;
    logic [4:0]  r_o_cnt_l;

    logic    pop_hit;
    t_level  pop_lvl;
    logic    add_full;
    logic    add_ok;
    logic    mem_we;
    logic    mem_re;
    t_addr   wr_addr;
    t_addr   rd_addr;

    always_comb begin
        pop_hit = 1'b1;
        pop_lvl = LVL_HIGH;
        priority if (r_count[LVL_HIGH] != '0) begin
            pop_lvl = LVL_HIGH;
        end else if (r_count[LVL_MEDIUM] != '0) begin
            pop_lvl = LVL_MEDIUM;
        end else if (r_count[LVL_LOW] != '0) begin
            pop_lvl = LVL_LOW;
        end else begin
            pop_hit = 1'b0;
        end
    end

    assign add_full = (r_prio != LVL_INVALID) &&
                      (r_count[r_prio] == t_cnt'(LEVEL_DEPTH));
    assign add_ok   = (r_kind == KIND_ADD) && (r_prio != LVL_INVALID) && !add_full;
    assign mem_we   = i_cmd.execute && add_ok;
    assign mem_re   = i_cmd.execute && (r_kind == KIND_POP) && pop_hit;
    assign wr_addr  = slot_addr(r_prio, r_tail[r_prio]);
    assign rd_addr  = slot_addr(pop_lvl, r_head[pop_lvl]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= r_handle;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // capture the item and the result of its step
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= t_kind'(i_kind);
            r_prio   <= i_priority_req;
            r_handle <= i_event_req[HANDLE_W-1:0];
        end
        if (i_cmd.execute) begin
            r_res_status <= ST_OK;
            r_res_level  <= LVL_HIGH;
            r_res_dlv    <= 1'b0;
            r_res_pop    <= 1'b0;
            unique case (r_kind)
                KIND_ADD: begin
                    if (r_prio == LVL_INVALID) begin
                        r_res_status <= ST_BADPRIO;
                    end else if (add_full) begin
                        r_res_status <= ST_FULL;
                    end
                end
                KIND_POP: begin
                    if (pop_hit) begin
                        r_res_level <= pop_lvl;
                        r_res_dlv   <= r_deliver_enable;
                        r_res_pop   <= 1'b1;
                    end else begin
                        r_res_status <= ST_EMPTY;
                    end
                end
                KIND_CLEAR, KIND_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // queue pointers, counts and the delivery register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_deliver_enable <= 1'b1;
        end else begin
            if (i_cfg_write) begin
                r_deliver_enable <= i_cfg_deliver_enable;
            end
            if (i_cmd.execute) begin
                if (add_ok) begin
                    r_tail[r_prio]  <= next_ptr(r_tail[r_prio]);
                    r_count[r_prio] <= r_count[r_prio] + t_cnt'(1);
                end else if (mem_re) begin
                    r_head[pop_lvl]  <= next_ptr(r_head[pop_lvl]);
                    r_count[pop_lvl] <= r_count[pop_lvl] - t_cnt'(1);
                end else if (r_kind == KIND_CLEAR) begin
                    for (int i = 0; i < NUM_LEVELS; i++) begin
                        r_head[i]  <= '0;
                        r_tail[i]  <= '0;
                        r_count[i] <= '0;
                    end
                end
            end
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status <= r_res_status;
            r_o_event  <= r_res_pop ? 32'(r_rd_data) : '0;
            r_o_level  <= r_res_level;
            r_o_dlv    <= r_res_dlv;
            r_o_cnt_h  <= cnt5(r_count[LVL_HIGH]);
            r_o_cnt_m  <= cnt5(r_count[LVL_MEDIUM]);
            r_o_cnt_l  <= cnt5(r_count[LVL_LOW]);
        end
    end

    assign o_status       = r_o_status;
    assign o_event_out    = r_o_event;
    assign o_level_out    = r_o_level;
    assign o_delivered    = r_o_dlv;
    assign o_count_high   = r_o_cnt_h;
    assign o_count_medium = r_o_cnt_m;
    assign o_count_low    = r_o_cnt_l;

endmodule

### rtl/three_level_priority_event_queue.sv
// ----------------------------------------------------------------------------
// three_level_priority_event_queue
// Strict-priority event queue with three FIFO levels of event handles.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  in        i_in_valid / o_in_stall    i_kind, i_event_req, i_priority_req
//  out       o_out_valid / i_out_stall  o_status, o_event_out, o_level_out,
//                                       o_delivered, o_count_high/medium/low
//  cfg       i_cfg_valid / o_cfg_ready  i_cfg_deliver_enable
//
//  An item passes capture, queue update with the event store access and result
//  load in turn; the registered read of the event store sets the middle step.
//  A new item is taken while an earlier result beat still waits at the output.
//  A stalled output holds the result load, and so the next item, until free.
//  Reset empties all levels and sets deliver_enable; the store needs no pass.
// ----------------------------------------------------------------------------
module three_level_priority_event_queue
    import tlpeq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_event_req,
    input  logic [1:0]  i_priority_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_event_out,
    output logic [1:0]  o_level_out,
    output logic        o_delivered,
    output logic [4:0]  o_count_high,
    output logic [4:0]  o_count_medium,
    output logic [4:0]  o_count_low,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_deliver_enable
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    tlpeq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    tlpeq_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_kind               (i_kind),
        .i_event_req          (i_event_req),
        .i_priority_req       (i_priority_req),
        .i_cfg_write          (i_cfg_valid),
        .i_cfg_deliver_enable (i_cfg_deliver_enable),
        .o_status             (o_status),
        .o_event_out          (o_event_out),
        .o_level_out          (o_level_out),
        .o_delivered          (o_delivered),
        .o_count_high         (o_count_high),
        .o_count_medium       (o_count_medium),
        .o_count_low          (o_count_low)
    );

endmodule

### dv/event_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_queue_checker
// Watches the add/pop/clear input, the result output and the delivery
// register write of the priority event queue. Keeps its own copy of the
// three levels, predicts one result per accepted input beat and compares
// every accepted result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module event_queue_checker
    import tlpeq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_event_req,
    input  logic [1:0]  i_priority_req,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_event_out,
    input  logic [1:0]  i_level_out,
    input  logic        i_delivered,
    input  logic [4:0]  i_count_high,
    input  logic [4:0]  i_count_medium,
    input  logic [4:0]  i_count_low,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_deliver_enable,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_results,
    output int          o_full_refusals,
    output int          o_empty_pops,
    output int          o_bad_levels
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        t_status     status;
        logic [31:0] handle;
        t_level      level;
        logic        delivered;
        logic [4:0]  count_high;
        logic [4:0]  count_medium;
        logic [4:0]  count_low;
    } t_queue_result;

    logic [31:0]   slots [NUM_LEVELS][LEVEL_DEPTH];
    int unsigned   heads [NUM_LEVELS];
    int unsigned   tails [NUM_LEVELS];
    int unsigned   fill  [NUM_LEVELS];
    logic          deliver_on = 1'b1;
    t_queue_result expected_results [$];

    int mismatch_total = 0;
    int result_total   = 0;
    int full_total     = 0;
    int empty_total    = 0;
    int badlvl_total   = 0;

    function automatic t_queue_result advance_queues(t_kind kind, logic [31:0] handle,
                                                     t_level lvl);
        t_queue_result r;
        bit            taken;
        r        = '0;
        r.status = ST_OK;
        taken    = 1'b0;
        case (kind)
            KIND_ADD: begin
                if (lvl == LVL_INVALID) begin
                    r.status = ST_BADPRIO;
                end else if (fill[lvl] >= LEVEL_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slots[lvl][tails[lvl]] = handle;
                    tails[lvl] = (tails[lvl] + 1) % LEVEL_DEPTH;
                    fill[lvl]++;
                end
            end
            KIND_POP: begin
                r.status = ST_EMPTY;
                for (int lv = 0; lv < NUM_LEVELS; lv++) begin
                    if (!taken && fill[lv] != 0) begin
                        r.handle    = slots[lv][heads[lv]];
                        heads[lv]   = (heads[lv] + 1) % LEVEL_DEPTH;
                        fill[lv]--;
                        r.level     = t_level'(lv);
                        r.delivered = deliver_on;
                        r.status    = ST_OK;
                        taken       = 1'b1;
                    end
                end
            end
            KIND_CLEAR: begin
                for (int lv = 0; lv < NUM_LEVELS; lv++) begin
                    heads[lv] = 0;
                    tails[lv] = 0;
                    fill[lv]  = 0;
                end
            end
            default: ;
        endcase
        r.count_high   = 5'(fill[0]);
        r.count_medium = 5'(fill[1]);
        r.count_low    = 5'(fill[2]);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_total++;
        if (mismatch_total <= MAX_PRINTED) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        end
    endtask

    task automatic compare_result(input t_queue_result want);
        if (i_status !== want.status)
            report_mismatch("status", 32'(i_status), 32'(want.status));
        if (i_event_out !== want.handle)
            report_mismatch("event_out", i_event_out, want.handle);
        if (i_level_out !== want.level)
            report_mismatch("level_out", 32'(i_level_out), 32'(want.level));
        if (i_delivered !== want.delivered)
            report_mismatch("delivered", 32'(i_delivered), 32'(want.delivered));
        if (i_count_high !== want.count_high)
            report_mismatch("count_high", 32'(i_count_high), 32'(want.count_high));
        if (i_count_medium !== want.count_medium)
            report_mismatch("count_medium", 32'(i_count_medium), 32'(want.count_medium));
        if (i_count_low !== want.count_low)
            report_mismatch("count_low", 32'(i_count_low), 32'(want.count_low));
    endtask

    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            for (int lv = 0; lv < NUM_LEVELS; lv++) begin
                heads[lv] = 0;
                tails[lv] = 0;
                fill[lv]  = 0;
            end
            deliver_on = 1'b1;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                deliver_on = i_cfg_deliver_enable;
            end
            if (i_out_valid && !i_out_stall) begin
                result_total++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 32'(i_status), '0);
                end else begin
                    want = expected_results.pop_front();
                    compare_result(want);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = advance_queues(t_kind'(i_kind), i_event_req, t_level'(i_priority_req));
                if (want.status == ST_FULL)    full_total++;
                if (want.status == ST_EMPTY)   empty_total++;
                if (want.status == ST_BADPRIO) badlvl_total++;
                expected_results.push_back(want);
            end
        end
        o_mismatches    <= mismatch_total;
        o_pending       <= expected_results.size();
        o_results       <= result_total;
        o_full_refusals <= full_total;
        o_empty_pops    <= empty_total;
        o_bad_levels    <= badlvl_total;
    end

endmodule

### dv/three_level_priority_event_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_level_priority_event_queue_tb
// Drives add, pop, clear and unused-kind beats into the priority event queue:
// a short directed pass over the corner cases, then random sequences that
// fill levels past full, drain them past empty and clear them, across phases
// of sender idling, receiver stalling and both delivery settings.
// ----------------------------------------------------------------------------
module three_level_priority_event_queue_tb
    import tlpeq_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 280;
    localparam int NUM_PHASES  = 5;
    localparam int TAIL_CYCLES = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_event_req = '0;
    logic [1:0]  i_priority_req = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_event_out;
    logic [1:0]  o_level_out;
    logic        o_delivered;
    logic [4:0]  o_count_high;
    logic [4:0]  o_count_medium;
    logic [4:0]  o_count_low;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_deliver_enable = 1'b1;

    int mismatches;
    int results_pending;
    int results_seen;
    int full_refusals;
    int empty_pops;
    int bad_levels;

    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int cfg_writes     = 0;

    int   send_plan    [NUM_PHASES] = '{0, 49, 0, 15, 0};
    int   stall_plan   [NUM_PHASES] = '{0, 0, 49, 15, 0};
    logic deliver_plan [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    three_level_priority_event_queue i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_kind               (i_kind),
        .i_event_req          (i_event_req),
        .i_priority_req       (i_priority_req),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_event_out          (o_event_out),
        .o_level_out          (o_level_out),
        .o_delivered          (o_delivered),
        .o_count_high         (o_count_high),
        .o_count_medium       (o_count_medium),
        .o_count_low          (o_count_low),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_deliver_enable (i_cfg_deliver_enable)
    );

    event_queue_checker queue_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_kind               (i_kind),
        .i_event_req          (i_event_req),
        .i_priority_req       (i_priority_req),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_status             (o_status),
        .i_event_out          (o_event_out),
        .i_level_out          (o_level_out),
        .i_delivered          (o_delivered),
        .i_count_high         (o_count_high),
        .i_count_medium       (o_count_medium),
        .i_count_low          (o_count_low),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_ready          (o_cfg_ready),
        .i_cfg_deliver_enable (i_cfg_deliver_enable),
        .o_mismatches         (mismatches),
        .o_pending            (results_pending),
        .o_results            (results_seen),
        .o_full_refusals      (full_refusals),
        .o_empty_pops         (empty_pops),
        .o_bad_levels         (bad_levels)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // hold the output for a long stretch on request, else stall at random
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            i_out_stall  <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic logic [31:0] random_handle();
        logic [31:0] h;
        case ($urandom_range(0, 15))
            0:       h = '0;
            1:       h = '1;
            default: h = $urandom();
        endcase
        return h;
    endfunction

    function automatic t_level random_level();
        t_level lvl;
        if ($urandom_range(0, 19) == 0) begin
            lvl = LVL_INVALID;
        end else begin
            lvl = t_level'($urandom_range(0, NUM_LEVELS - 1));
        end
        return lvl;
    endfunction

    task automatic send_item(input t_kind kind, input logic [31:0] handle, input t_level lvl);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_event_req    <= handle;
        i_priority_req <= lvl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (kind != KIND_NONE) items_sent++;
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    task automatic set_delivery(input logic enable);
        wait_for_drain();
        i_cfg_valid          <= 1'b1;
        i_cfg_deliver_enable <= enable;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_random_sequence();
        int shape;
        int len;
        int pick;
        t_level lvl;
        shape = $urandom_range(0, 8);
        if (shape <= 4) begin
            len = $urandom_range(8, 24);
            for (int n = 0; n < len; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 52) begin
                    send_item(KIND_ADD, random_handle(), random_level());
                end else if (pick < 92) begin
                    send_item(KIND_POP, random_handle(), random_level());
                end else if (pick < 96) begin
                    send_item(KIND_CLEAR, random_handle(), random_level());
                end else begin
                    send_item(KIND_NONE, random_handle(), random_level());
                end
            end
        end else if (shape <= 6) begin
            lvl = t_level'($urandom_range(0, NUM_LEVELS - 1));
            repeat (LEVEL_DEPTH + $urandom_range(1, 3))
                send_item(KIND_ADD, random_handle(), lvl);
            repeat ($urandom_range(2, LEVEL_DEPTH))
                send_item(KIND_POP, random_handle(), random_level());
        end else if (shape == 7) begin
            repeat (NUM_LEVELS * LEVEL_DEPTH + 2)
                send_item(KIND_ADD, random_handle(), t_level'($urandom_range(0, NUM_LEVELS - 1)));
            repeat (NUM_LEVELS * LEVEL_DEPTH + 3)
                send_item(KIND_POP, random_handle(), random_level());
        end else begin
            repeat ($urandom_range(2, 10))
                send_item(KIND_ADD, random_handle(), random_level());
            send_item(KIND_CLEAR, random_handle(), random_level());
            repeat ($urandom_range(1, 4))
                send_item(KIND_POP, random_handle(), random_level());
        end
    endtask

    initial begin
        int phase_start;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(KIND_POP,   32'h1234_5678, LVL_HIGH);
        send_item(KIND_ADD,   32'h0000_0000, LVL_LOW);
        send_item(KIND_ADD,   32'hFFFF_FFFF, LVL_MEDIUM);
        send_item(KIND_ADD,   32'hA5A5_5A5A, LVL_HIGH);
        send_item(KIND_ADD,   32'h5A5A_A5A5, LVL_INVALID);
        send_item(KIND_NONE,  32'hFFFF_FFFF, LVL_INVALID);
        repeat (4) send_item(KIND_POP, 32'hFFFF_FFFF, LVL_INVALID);
        send_item(KIND_ADD,   32'hC3C3_3C3C, LVL_MEDIUM);
        send_item(KIND_ADD,   32'h0F0F_F0F0, LVL_HIGH);
        send_item(KIND_CLEAR, 32'hFFFF_FFFF, LVL_INVALID);
        send_item(KIND_POP,   32'h0000_0000, LVL_HIGH);
        set_delivery(1'b0);
        send_item(KIND_ADD,   32'h8000_0001, LVL_LOW);
        send_item(KIND_POP,   32'h0000_0000, LVL_HIGH);
        send_item(KIND_POP,   32'h0000_0000, LVL_HIGH);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_delivery(deliver_plan[phase]);
            send_idle_pct  = send_plan[phase];
            recv_stall_pct <= stall_plan[phase];
            if (phase == 0 || phase == NUM_PHASES - 1) begin
                hold_requests <= hold_requests + 1;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) run_random_sequence();
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d queue operations and %0d delivery writes; checked %0d results",
                 items_sent, cfg_writes, results_seen);
        $display("Saw %0d adds to a full level, %0d pops on empty, %0d invalid levels",
                 full_refusals, empty_pops, bad_levels);
        if (mismatches == 0 && results_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/tlpeq_pkg.sv
rtl/tlpeq_ctrl.sv
rtl/tlpeq_dp.sv
rtl/three_level_priority_event_queue.sv
dv/event_queue_checker.sv
dv/three_level_priority_event_queue_tb.sv
